// ===== rtl/rldc_pkg.sv =====
// Shared types, constants and helpers of the remote lamp dimming controller.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none
package rldc_pkg;

    // Timing of the tick chain: 100 ticks make 10 ms, 100 of those make 1 s.
    localparam logic [6:0]  STEPS_PER_SLOT = 7'd100;
    localparam logic [3:0]  RUN_LIMIT      = 4'd10;
    localparam logic [11:0] TIMER_SHORT_S  = 12'd1800;
    localparam logic [11:0] TIMER_LONG_S   = 12'd3600;

    localparam logic [15:0] BEEP_ON_RESET  = 16'd1000;
    localparam logic [15:0] BEEP_GAP_RESET = 16'd1000;

    // Configuration register indexes.
    localparam logic [1:0] REG_COMMAND_CODES = 2'd0;
    localparam logic [1:0] REG_CHANNEL_CODES = 2'd1;
    localparam logic [1:0] REG_BEEP_ON       = 2'd2;
    localparam logic [1:0] REG_BEEP_GAP      = 2'd3;

    // Command slots inside command_codes, from the low byte up.
    localparam logic [2:0] CMD_TIMER30  = 3'd0;
    localparam logic [2:0] CMD_TIMER60  = 3'd1;
    localparam logic [2:0] CMD_PRESET56 = 3'd2;
    localparam logic [2:0] CMD_PRESET43 = 3'd3;
    localparam logic [2:0] CMD_PRESET35 = 3'd4;
    localparam logic [2:0] CMD_PRESET28 = 3'd5;
    localparam logic [2:0] CMD_NIGHT    = 3'd6;
    localparam logic [2:0] CMD_POWER    = 3'd7;

    localparam int unsigned CMD_SLOTS = 8;

    // Item kinds carried on tuser.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    localparam logic [8:0] PWM_MAX = 9'd280;

    typedef struct packed {
        logic       kind;
        logic [7:0] ir_command;
        logic [7:0] ir_channel;
        logic       switch_level;
    } item_t;

    typedef struct packed {
        logic [63:0] command_codes;
        logic [15:0] channel_codes;
        logic [15:0] beep_on_ticks;
        logic [15:0] beep_gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic [8:0] pwm_percent;
        logic       night_light;
        logic       buzzer;
    } result_t;

    function automatic logic [5:0] preset_level(input logic [2:0] slot);
        logic [5:0] lvl;
        case (slot)
            CMD_PRESET56: lvl = 6'd56;
            CMD_PRESET43: lvl = 6'd43;
            CMD_PRESET35: lvl = 6'd35;
            default:      lvl = 6'd28;
        endcase
        return lvl;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rldc_cfg_regs.sv =====
// Configuration register file of the lamp controller: write-only, one write per cycle.
// Depends on rldc_pkg.
`default_nettype none
module rldc_cfg_regs (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [63:0]    cfg_wdata,
    output rldc_pkg::cfg_t      cfg
);

    rldc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.command_codes  <= '0;
            cfg_reg.channel_codes  <= '0;
            cfg_reg.beep_on_ticks  <= rldc_pkg::BEEP_ON_RESET;
            cfg_reg.beep_gap_ticks <= rldc_pkg::BEEP_GAP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rldc_pkg::REG_COMMAND_CODES: cfg_reg.command_codes  <= cfg_wdata;
                rldc_pkg::REG_CHANNEL_CODES: cfg_reg.channel_codes  <= cfg_wdata[15:0];
                rldc_pkg::REG_BEEP_ON:       cfg_reg.beep_on_ticks  <= cfg_wdata[15:0];
                rldc_pkg::REG_BEEP_GAP:      cfg_reg.beep_gap_ticks <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/rldc_in_stage.sv =====
// Input register of the lamp controller: captures one transfer and holds it until the
// engine takes it. Depends on rldc_pkg.
`default_nettype none
module rldc_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  rldc_pkg::item_t s_item,
    output logic            item_valid,
    input  wire logic       item_take,
    output rldc_pkg::item_t item
);

    logic            valid_reg;
    rldc_pkg::item_t item_reg;

    assign s_ready = !valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

// ===== rtl/rldc_engine.sv =====
// Lamp state and its update for one tick or one remote command per step.
// Holds level, night mode, auto-off timer, debounce and buzzer state. Depends on rldc_pkg.
`default_nettype none
module rldc_engine (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         step,
    input  rldc_pkg::item_t   item,
    input  rldc_pkg::cfg_t    cfg,
    output rldc_pkg::result_t result
);

    logic [5:0]  level_reg,          level_next;
    logic [5:0]  saved_level_reg,    saved_level_next;
    logic        night_mode_reg,     night_mode_next;
    logic        night_line_reg,     night_line_next;
    logic [11:0] off_limit_reg,      off_limit_next;
    logic [11:0] off_seconds_reg,    off_seconds_next;
    logic [6:0]  tick_count_reg,     tick_count_next;
    logic [6:0]  tenms_count_reg,    tenms_count_next;
    logic [7:0]  active_channel_reg, active_channel_next;
    logic [3:0]  high_run_reg,       high_run_next;
    logic [3:0]  low_run_reg,        low_run_next;
    logic        beep_running_reg,   beep_running_next;
    logic [16:0] beep_ticks_reg,     beep_ticks_next;
    logic [1:0]  beeps_done_reg,     beeps_done_next;
    logic [1:0]  beeps_wanted_reg,   beeps_wanted_next;
    logic        buzzer_line_reg,    buzzer_line_next;

    logic [16:0] beep_period;
    logic [7:0]  cmd_hit;
    logic        cmd_found;
    logic [2:0]  cmd_slot;
    logic        start_beep;
    logic [1:0]  beep_count;
    logic [5:0]  level_out;

    assign beep_period = {1'b0, cfg.beep_on_ticks} + {1'b0, cfg.beep_gap_ticks};

    // Compare the command byte against every slot; the lowest matching slot wins.
    always_comb begin
        for (int i = 0; i < rldc_pkg::CMD_SLOTS; i++) begin
            cmd_hit[i] = (cfg.command_codes[8*i +: 8] == item.ir_command);
        end
        cmd_found = |cmd_hit;
        cmd_slot  = '0;
        for (int i = rldc_pkg::CMD_SLOTS - 1; i >= 0; i--) begin
            if (cmd_hit[i]) begin
                cmd_slot = 3'(i);
            end
        end
    end

    always_comb begin
        level_next          = level_reg;
        saved_level_next    = saved_level_reg;
        night_mode_next     = night_mode_reg;
        night_line_next     = night_line_reg;
        off_limit_next      = off_limit_reg;
        off_seconds_next    = off_seconds_reg;
        tick_count_next     = tick_count_reg;
        tenms_count_next    = tenms_count_reg;
        active_channel_next = active_channel_reg;
        high_run_next       = high_run_reg;
        low_run_next        = low_run_reg;
        beep_running_next   = beep_running_reg;
        beep_ticks_next     = beep_ticks_reg;
        beeps_done_next     = beeps_done_reg;
        beeps_wanted_next   = beeps_wanted_reg;
        buzzer_line_next    = buzzer_line_reg;
        start_beep          = 1'b0;
        beep_count          = 2'd1;

        if (item.kind == rldc_pkg::KIND_TICK) begin
            // Buzzer sequencer: on phase, then silent gap, repeated per beep.
            if (beep_running_reg) begin
                beep_ticks_next  = beep_ticks_reg + 17'd1;
                buzzer_line_next = (beep_ticks_reg <= {1'b0, cfg.beep_on_ticks});
                if (beep_ticks_next >= beep_period) begin
                    beep_ticks_next = '0;
                    beeps_done_next = beeps_done_reg + 2'd1;
                    if (beeps_done_next >= beeps_wanted_reg) begin
                        beep_running_next = 1'b0;
                        buzzer_line_next  = 1'b0;
                    end
                end
            end

            tick_count_next = tick_count_reg + 7'd1;
            if (tick_count_next >= rldc_pkg::STEPS_PER_SLOT) begin
                tick_count_next  = '0;
                tenms_count_next = tenms_count_reg + 7'd1;

                // Debounce the channel switch every 10 ms; runs saturate.
                active_channel_next = '0;
                if (item.switch_level) begin
                    low_run_next = '0;
                    if (high_run_reg > rldc_pkg::RUN_LIMIT) begin
                        active_channel_next = cfg.channel_codes[7:0];
                    end else begin
                        high_run_next = high_run_reg + 4'd1;
                    end
                end else begin
                    high_run_next = '0;
                    if (low_run_reg > rldc_pkg::RUN_LIMIT) begin
                        active_channel_next = cfg.channel_codes[15:8];
                    end else begin
                        low_run_next = low_run_reg + 4'd1;
                    end
                end

                if (tenms_count_next >= rldc_pkg::STEPS_PER_SLOT) begin
                    tenms_count_next = '0;
                    // One second of the auto-off timer.
                    if (off_limit_reg != '0) begin
                        off_seconds_next = off_seconds_reg + 12'd1;
                        if (off_seconds_next >= off_limit_reg) begin
                            off_limit_next   = '0;
                            off_seconds_next = '0;
                            level_next       = '0;
                            night_line_next  = 1'b0;
                        end
                    end
                end
            end
        end else if (item.ir_channel == active_channel_reg && cmd_found) begin
            start_beep = 1'b1;
            unique case (cmd_slot)
                rldc_pkg::CMD_TIMER30, rldc_pkg::CMD_TIMER60: begin
                    if (off_limit_reg == '0) begin
                        off_limit_next = (cmd_slot == rldc_pkg::CMD_TIMER30) ?
                                         rldc_pkg::TIMER_SHORT_S : rldc_pkg::TIMER_LONG_S;
                    end else begin
                        off_limit_next   = '0;
                        off_seconds_next = '0;
                        beep_count       = 2'd2;
                    end
                end
                rldc_pkg::CMD_PRESET56, rldc_pkg::CMD_PRESET43,
                rldc_pkg::CMD_PRESET35, rldc_pkg::CMD_PRESET28: begin
                    level_next       = rldc_pkg::preset_level(cmd_slot);
                    saved_level_next = level_next;
                    night_mode_next  = 1'b0;
                end
                rldc_pkg::CMD_NIGHT: begin
                    level_next      = '0;
                    night_mode_next = !night_mode_reg;
                end
                default: begin
                    level_next      = (level_reg == '0) ? saved_level_reg : 6'd0;
                    night_mode_next = 1'b0;
                end
            endcase
            night_line_next = night_mode_next;
        end

        // Restart the beep sequence; the buzzer line itself changes on the next tick.
        if (start_beep) begin
            beep_ticks_next   = '0;
            beeps_done_next   = '0;
            beeps_wanted_next = beep_count;
            beep_running_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg          <= '0;
            saved_level_reg    <= '0;
            night_mode_reg     <= 1'b0;
            night_line_reg     <= 1'b0;
            off_limit_reg      <= '0;
            off_seconds_reg    <= '0;
            tick_count_reg     <= '0;
            tenms_count_reg    <= '0;
            active_channel_reg <= '0;
            high_run_reg       <= '0;
            low_run_reg        <= '0;
            beep_running_reg   <= 1'b0;
            beep_ticks_reg     <= '0;
            beeps_done_reg     <= '0;
            beeps_wanted_reg   <= '0;
            buzzer_line_reg    <= 1'b0;
        end else if (step) begin
            level_reg          <= level_next;
            saved_level_reg    <= saved_level_next;
            night_mode_reg     <= night_mode_next;
            night_line_reg     <= night_line_next;
            off_limit_reg      <= off_limit_next;
            off_seconds_reg    <= off_seconds_next;
            tick_count_reg     <= tick_count_next;
            tenms_count_reg    <= tenms_count_next;
            active_channel_reg <= active_channel_next;
            high_run_reg       <= high_run_next;
            low_run_reg        <= low_run_next;
            beep_running_reg   <= beep_running_next;
            beep_ticks_reg     <= beep_ticks_next;
            beeps_done_reg     <= beeps_done_next;
            beeps_wanted_reg   <= beeps_wanted_next;
            buzzer_line_reg    <= buzzer_line_next;
        end
    end

    // Result reflects the state after this item: level * 5 as (level << 2) + level.
    assign level_out          = level_next;
    assign result.pwm_percent = {1'b0, level_out, 2'b00} + {3'b000, level_out};
    assign result.night_light = night_line_next;
    assign result.buzzer      = buzzer_line_next;

endmodule
`default_nettype wire

// ===== rtl/remote_lamp_dimming_controller_unit.sv =====
// Remote lamp dimming controller, top level.
// Path: an accepted item is held in the input register; its result is then held in
// the result register until it transfers.
// Throughput: one item per cycle unless m_tready stalls; state update is combinational logic.
// Reset: synchronous, active low; clears lamp, timer, debounce and buzzer state and
// loads the configuration defaults (beep on and gap lengths of 1000 ticks).
// Depends on rldc_pkg, rldc_cfg_regs, rldc_in_stage, rldc_engine.
`default_nettype none
module remote_lamp_dimming_controller_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // ir_command[7:0], ir_channel[15:8], switch_level[16]
    input  wire logic        s_tuser,   // kind: 0 tick, 1 remote command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // pwm_percent[8:0], night_light[9], buzzer[10]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);

    rldc_pkg::cfg_t    cfg;
    rldc_pkg::item_t   s_item;
    rldc_pkg::item_t   item;
    rldc_pkg::result_t result;
    rldc_pkg::result_t out_reg;
    logic              item_valid;
    logic              out_valid_reg;
    logic              out_free;
    logic              step;

    assign s_item.kind         = s_tuser;
    assign s_item.ir_command   = s_tdata[7:0];
    assign s_item.ir_channel   = s_tdata[15:8];
    assign s_item.switch_level = s_tdata[16];

    rldc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rldc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_take  (step),
        .item       (item)
    );

    // Advance an item whenever the result register is empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign step     = item_valid && out_free;

    rldc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_reg.buzzer, out_reg.night_light, out_reg.pwm_percent};

`ifndef SYNTHESIS
    a_pwm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:0] <= rldc_pkg::PWM_MAX))
        else $error("lamp drive above full scale");

    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("engine step produced no result");

    a_blocked_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while input register is held");

    a_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> item_valid)
        else $error("accepted transfer lost in input register");
`endif

endmodule
`default_nettype wire

// ===== dv/rldc_result_check.sv =====
// Result checker for the remote lamp dimming controller: follows the register
// port and both stream channels, predicts every result and compares it.
// Depends on rldc_pkg for item_t, result_t and the register and command codes.
`timescale 1ns / 100ps
module rldc_result_check (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // ir_command[7:0], ir_channel[15:8], switch_level[16]
    input  wire logic        s_tuser,   // kind: 0 tick, 1 remote command
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // pwm_percent[8:0], night_light[9], buzzer[10]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    output int               mismatches,
    output int               outstanding
);

    localparam logic [6:0]  TICKS_PER_STEP   = 7'd100;
    localparam logic [6:0]  STEPS_PER_SECOND = 7'd100;
    localparam logic [3:0]  RUN_SATURATE     = 4'd10;
    localparam logic [11:0] SHORT_OFF_S      = 12'd1800;
    localparam logic [11:0] LONG_OFF_S       = 12'd3600;

    // register copies
    logic [63:0] cmd_codes;
    logic [15:0] chan_codes;
    logic [15:0] beep_on_len;
    logic [15:0] beep_gap_len;

    // lamp, timer, debounce and buzzer state
    logic [5:0]  lamp_lvl;
    logic [5:0]  stored_lvl;
    logic        night_on;
    logic        night_out;
    logic [11:0] auto_off_s;
    logic [11:0] elapsed_s;
    logic [6:0]  tick_div;
    logic [6:0]  step_div;
    logic [7:0]  live_chan;
    logic [3:0]  hi_steps;
    logic [3:0]  lo_steps;
    logic        beep_active;
    logic [16:0] beep_pos;
    logic [1:0]  beep_count;
    logic [1:0]  beep_target;
    logic        buzz_out;

    rldc_pkg::result_t lamp_results_q[$];

    task automatic start_beeps(input logic [1:0] n);
        beep_pos    = '0;
        beep_count  = '0;
        beep_target = n;
        beep_active = 1'b1;
    endtask

    task automatic advance_lamp(input rldc_pkg::item_t it, output rldc_pkg::result_t res);
        logic [16:0] prev_pos;
        logic [7:0]  chan;
        int          slot;
        int          i;
        if (it.kind == rldc_pkg::KIND_TICK) begin
            if (beep_active) begin
                prev_pos = beep_pos;
                beep_pos = prev_pos + 17'd1;
                buzz_out = (prev_pos <= {1'b0, beep_on_len});
                if (beep_pos >= {1'b0, beep_on_len} + {1'b0, beep_gap_len}) begin
                    beep_pos   = '0;
                    beep_count = beep_count + 2'd1;
                    if (beep_count >= beep_target) begin
                        beep_active = 1'b0;
                        buzz_out    = 1'b0;
                    end
                end
            end
            tick_div = tick_div + 7'd1;
            if (tick_div >= TICKS_PER_STEP) begin
                tick_div = '0;
                step_div = step_div + 7'd1;
                // debounce: runs saturate, channel only after a long steady run
                chan = '0;
                if (it.switch_level) begin
                    lo_steps = '0;
                    if (hi_steps > RUN_SATURATE) chan = chan_codes[7:0];
                    else hi_steps = hi_steps + 4'd1;
                end else begin
                    hi_steps = '0;
                    if (lo_steps > RUN_SATURATE) chan = chan_codes[15:8];
                    else lo_steps = lo_steps + 4'd1;
                end
                live_chan = chan;
                if (step_div >= STEPS_PER_SECOND) begin
                    step_div = '0;
                    if (auto_off_s != 0) begin
                        elapsed_s = elapsed_s + 12'd1;
                        if (elapsed_s >= auto_off_s) begin
                            auto_off_s = '0;
                            elapsed_s  = '0;
                            lamp_lvl   = '0;
                            night_out  = 1'b0;
                        end
                    end
                end
            end
        end else if (it.ir_channel == live_chan) begin
            // scan downward so the lowest matching slot wins
            slot = -1;
            for (i = rldc_pkg::CMD_SLOTS - 1; i >= 0; i--) begin
                if (cmd_codes[8*i +: 8] == it.ir_command) slot = i;
            end
            if (slot >= 0) begin
                case (slot)
                    rldc_pkg::CMD_TIMER30, rldc_pkg::CMD_TIMER60: begin
                        if (auto_off_s == 0) begin
                            auto_off_s = (slot == rldc_pkg::CMD_TIMER30) ?
                                         SHORT_OFF_S : LONG_OFF_S;
                            start_beeps(2'd1);
                        end else begin
                            auto_off_s = '0;
                            elapsed_s  = '0;
                            start_beeps(2'd2);
                        end
                    end
                    rldc_pkg::CMD_PRESET56, rldc_pkg::CMD_PRESET43,
                    rldc_pkg::CMD_PRESET35, rldc_pkg::CMD_PRESET28: begin
                        case (slot)
                            rldc_pkg::CMD_PRESET56: lamp_lvl = 6'd56;
                            rldc_pkg::CMD_PRESET43: lamp_lvl = 6'd43;
                            rldc_pkg::CMD_PRESET35: lamp_lvl = 6'd35;
                            default:                lamp_lvl = 6'd28;
                        endcase
                        stored_lvl = lamp_lvl;
                        night_on   = 1'b0;
                        start_beeps(2'd1);
                    end
                    rldc_pkg::CMD_NIGHT: begin
                        lamp_lvl = '0;
                        night_on = ~night_on;
                        start_beeps(2'd1);
                    end
                    default: begin
                        lamp_lvl = (lamp_lvl == 0) ? stored_lvl : 6'd0;
                        night_on = 1'b0;
                        start_beeps(2'd1);
                    end
                endcase
                night_out = night_on;
            end
        end
        res.pwm_percent = {3'b000, lamp_lvl} * 9'd5;
        res.night_light = night_out;
        res.buzzer      = buzz_out;
    endtask

    always @(posedge aclk) begin
        rldc_pkg::item_t   it;
        rldc_pkg::result_t want;
        rldc_pkg::result_t got;
        if (!aresetn) begin
            cmd_codes    = '0;
            chan_codes   = '0;
            beep_on_len  = 16'd1000;
            beep_gap_len = 16'd1000;
            lamp_lvl     = '0;
            stored_lvl   = '0;
            night_on     = 1'b0;
            night_out    = 1'b0;
            auto_off_s   = '0;
            elapsed_s    = '0;
            tick_div     = '0;
            step_div     = '0;
            live_chan    = '0;
            hi_steps     = '0;
            lo_steps     = '0;
            beep_active  = 1'b0;
            beep_pos     = '0;
            beep_count   = '0;
            beep_target  = '0;
            buzz_out     = 1'b0;
            mismatches   = 0;
            lamp_results_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    rldc_pkg::REG_COMMAND_CODES: cmd_codes    = cfg_wdata;
                    rldc_pkg::REG_CHANNEL_CODES: chan_codes   = cfg_wdata[15:0];
                    rldc_pkg::REG_BEEP_ON:       beep_on_len  = cfg_wdata[15:0];
                    rldc_pkg::REG_BEEP_GAP:      beep_gap_len = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            // compare before pushing: a result never belongs to the item of the same edge
            if (m_tvalid && m_tready) begin
                got.pwm_percent = m_tdata[8:0];
                got.night_light = m_tdata[9];
                got.buzzer      = m_tdata[10];
                if (lamp_results_q.size() == 0) begin
                    mismatches++;
                    $display({"%0t: unexpected result transfer, expected none, ",
                              "got pwm %0d night %0b buzzer %0b"},
                             $time, got.pwm_percent, got.night_light, got.buzzer);
                end else begin
                    want = lamp_results_q.pop_front();
                    if (got.pwm_percent !== want.pwm_percent) begin
                        mismatches++;
                        $display("%0t: pwm_percent expected %0d, got %0d",
                                 $time, want.pwm_percent, got.pwm_percent);
                    end
                    if (got.night_light !== want.night_light) begin
                        mismatches++;
                        $display("%0t: night_light expected %0b, got %0b",
                                 $time, want.night_light, got.night_light);
                    end
                    if (got.buzzer !== want.buzzer) begin
                        mismatches++;
                        $display("%0t: buzzer expected %0b, got %0b",
                                 $time, want.buzzer, got.buzzer);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                it.kind         = s_tuser;
                it.ir_command   = s_tdata[7:0];
                it.ir_channel   = s_tdata[15:8];
                it.switch_level = s_tdata[16];
                advance_lamp(it, want);
                lamp_results_q.push_back(want);
            end
        end
        outstanding <= lamp_results_q.size();
    end

endmodule

// ===== dv/remote_lamp_dimming_controller_unit_tb.sv =====
// Testbench top for remote_lamp_dimming_controller_unit: drives ticks, remote
// commands and register writes with random gaps and back-pressure.
// Depends on rldc_pkg, the RTL top and rldc_result_check.
`timescale 1ns / 100ps
module remote_lamp_dimming_controller_unit_tb;

    localparam int QUIET_LIMIT = 1000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_wdata;

    int mismatches;
    int outstanding;
    int n_sent      = 0;
    int n_done      = 0;
    int n_ticks     = 0;
    int n_cmds      = 0;
    int n_settings  = 0;
    int quiet_count = 0;

    logic        tx_idle = 1'b1;
    logic        rx_idle = 1'b1;
    logic        sw_now  = 1'b0;
    logic [63:0] cur_cmd_codes  = '0;
    logic [15:0] cur_chan_codes = '0;

    remote_lamp_dimming_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rldc_result_check u_result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side: random stalls, one draw per result
    initial begin
        int gap;
        forever begin
            gap = rx_idle ? $urandom_range(0, 19) : 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) n_done <= n_done + 1;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= QUIET_LIMIT) begin
            $display("remote_lamp_dimming_controller_unit_tb: errors");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // s_tvalid stays high after a transfer; the next call either refills or drops it
    task automatic send_item(input logic kind, input logic [7:0] cmd,
                             input logic [7:0] chan, input logic sw);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, sw, chan, cmd};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        if (kind == rldc_pkg::KIND_TICK) n_ticks++;
        else n_cmds++;
    endtask

    task automatic tick(input logic sw);
        send_item(rldc_pkg::KIND_TICK, 8'($urandom), 8'($urandom), sw);
    endtask

    task automatic raw_command(input logic [7:0] cmd, input logic [7:0] chan);
        send_item(rldc_pkg::KIND_COMMAND, cmd, chan, 1'($urandom));
    endtask

    task automatic command(input logic [2:0] slot, input logic [7:0] chan);
        raw_command(cur_cmd_codes[8*slot +: 8], chan);
    endtask

    // hold the sender until every result is back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (n_done != n_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [63:0] codes, input logic [15:0] chans,
                            input logic [15:0] on_len, input logic [15:0] gap_len);
        cfg_we    <= 1'b1;
        cfg_index <= rldc_pkg::REG_COMMAND_CODES;
        cfg_wdata <= codes;
        @(posedge aclk);
        cfg_index <= rldc_pkg::REG_CHANNEL_CODES;
        cfg_wdata <= {$urandom, 16'($urandom), chans};
        @(posedge aclk);
        cfg_index <= rldc_pkg::REG_BEEP_ON;
        cfg_wdata <= {$urandom, 16'($urandom), on_len};
        @(posedge aclk);
        cfg_index <= rldc_pkg::REG_BEEP_GAP;
        cfg_wdata <= {$urandom, 16'($urandom), gap_len};
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_cmd_codes  = codes;
        cur_chan_codes = chans;
        n_settings++;
    endtask

    function automatic logic [7:0] pick_code();
        int slot;
        slot = $urandom_range(0, 7);
        if ($urandom_range(0, 4) != 0) return cur_cmd_codes[8*slot +: 8];
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_chan();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 8'd0;
        if (r < 7) return cur_chan_codes[7:0];
        if (r < 9) return cur_chan_codes[15:8];
        return 8'($urandom);
    endfunction

    initial begin
        int          p;
        int          k;
        int          n_items;
        int          cmd_pct;
        logic        hold_sw;
        logic [63:0] codes;
        logic [15:0] chans;
        logic [15:0] on_len;
        logic [15:0] gap_len;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset codes are all zero: command 0 hits the first slot, the 30 min timer
        raw_command(8'h00, 8'h00);
        raw_command(8'h00, 8'h00);
        tick(1'b1);
        tick(1'b0);
        drain();

        set_regs(64'hFF80_4433_2211_7F00, 16'h5AA5, 16'd2, 16'd3);
        command(rldc_pkg::CMD_POWER, 8'h00);      // power on with no preset saved
        command(rldc_pkg::CMD_PRESET56, 8'h00);
        command(rldc_pkg::CMD_PRESET43, 8'h00);
        command(rldc_pkg::CMD_PRESET35, 8'h00);
        command(rldc_pkg::CMD_PRESET28, 8'h00);
        command(rldc_pkg::CMD_POWER, 8'h00);
        command(rldc_pkg::CMD_POWER, 8'h00);
        command(rldc_pkg::CMD_NIGHT, 8'h00);
        command(rldc_pkg::CMD_NIGHT, 8'h00);
        command(rldc_pkg::CMD_NIGHT, 8'h00);
        command(rldc_pkg::CMD_POWER, 8'h00);
        command(rldc_pkg::CMD_TIMER30, 8'h00);
        command(rldc_pkg::CMD_TIMER60, 8'h00);    // armed: cancel with two beeps
        command(rldc_pkg::CMD_TIMER60, 8'h00);
        command(rldc_pkg::CMD_TIMER30, 8'h00);
        raw_command(8'h55, 8'h00);                // unknown code
        command(rldc_pkg::CMD_PRESET56, 8'hA5);   // wrong channel
        repeat (8) tick(1'b1);
        drain();

        for (p = 0; p < 8; p++) begin
            codes   = {$urandom, $urandom};
            chans   = 16'($urandom);
            on_len  = 16'($urandom_range(0, 9));
            gap_len = 16'($urandom_range(0, 9));
            if ($urandom_range(0, 3) == 0) on_len = 16'($urandom);
            case (p)
                0: begin
                    codes = '0; chans = '0; on_len = '0; gap_len = '0;
                end
                1: begin
                    codes = '1; chans = '1; on_len = '1; gap_len = '1;
                end
                4: begin
                    on_len = 16'd1000; gap_len = 16'd1000;
                end
                default: ;
            endcase
            set_regs(codes, chans, on_len, gap_len);

            // one long steady switch run lets the debounce latch a channel byte
            hold_sw = (p == 2);
            if (hold_sw) sw_now = 1'b1;
            n_items = hold_sw ? 1500 : 40;
            cmd_pct = hold_sw ? 5 : 30;
            for (k = 0; k < n_items; k++) begin
                if (k % 50 == 0) begin
                    tx_idle = ($urandom_range(0, 2) != 0);
                    rx_idle = ($urandom_range(0, 2) != 0);
                end
                if ($urandom_range(0, 99) < cmd_pct) begin
                    raw_command(pick_code(), pick_chan());
                end else begin
                    if (!hold_sw && $urandom_range(0, 299) == 0) sw_now = ~sw_now;
                    tick(sw_now);
                end
                if ($urandom_range(0, 149) == 0) drain();
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        $display("ran %0d items (%0d ticks, %0d commands) under %0d register settings",
                 n_sent, n_ticks, n_cmds, n_settings);
        $display("included beep lengths from 0 to 65535 and a switch run long enough to latch");
        if (mismatches == 0 && outstanding == 0) begin
            $display("remote_lamp_dimming_controller_unit_tb: clean");
        end else begin
            $display("remote_lamp_dimming_controller_unit_tb: errors");
        end
        $finish;
    end

endmodule
